@@ rtl/core/credit_limited_chunk_scheduler_top_macros.svh @@
// assertion macros for the chunk scheduler
`ifndef CREDIT_LIMITED_CHUNK_SCHEDULER_TOP_MACROS_SVH
`define CREDIT_LIMITED_CHUNK_SCHEDULER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cls_pkg.sv @@
`default_nettype none

package cls_pkg;

  // table and counter sizes
  localparam int SLOTS       = 4;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int MAX_CREDITS = 16;
  localparam int CRED_W      = $clog2(MAX_CREDITS + 1);
  localparam int SEQ_BITS    = 16;
  localparam int OUT_W       = 5;
  localparam int OUT_MAX     = 31;
  localparam int ADDR_W      = 32;
  localparam int BLK_W       = 21;
  localparam int CHUNK_MAX   = 1048576;
  localparam int INIT_W      = 5;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // register reset values
  localparam logic [BLK_W-1:0]  BLOCK_BYTES_RST = BLK_W'(4096);
  localparam logic [INIT_W-1:0] INIT_CREDITS_RST = INIT_W'(4);
  localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = '0;
  localparam logic [ADDR_W-1:0] WINDOW_SIZE_RST = 32'h8000_0000;

  // result kinds
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SUBMIT = 2'd1,
    FUNC_ACK    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BUSY   = 2'd1,
    STAT_REJECT = 2'd2,
    STAT_ERROR  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_BLOCK_BYTES  = 2'd0,
    REG_INIT_CREDITS = 2'd1,
    REG_WINDOW_BASE  = 2'd2,
    REG_WINDOW_SIZE  = 2'd3
  } reg_e;

  // how the final status of a transaction is formed
  typedef enum logic [2:0] {
    FIN_OK,
    FIN_REJECT,
    FIN_ERROR,
    FIN_SUBMIT,
    FIN_ACK
  } fin_e;

  typedef struct packed {
    logic [BLK_W-1:0]  block_bytes;
    logic [INIT_W-1:0] initial_credits;
    logic [ADDR_W-1:0] window_base;
    logic [ADDR_W-1:0] window_size;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              sum;
    logic              alloc;
    logic              credit;
    logic              walk;
    logic              issue;
    logic              emit_fin;
    logic [SLOT_W-1:0] walk_idx;
    fin_e              fin;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic no_free;
    logic can_issue;
    logic ends_buf;
    logic walk_freed;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/credit_limited_chunk_scheduler_top.sv @@
// throughput: one transaction at a time; the next start is taken in the cycle the final
//   status is shown; the slot walk and the one-chunk-per-cycle issue loop set the rate
// the receiver cannot stall: each result is shown for exactly one cycle on valid_o
// reset: asynchronous active low; empties the slot table, zeroes credits and sequences
`default_nettype none
`include "credit_limited_chunk_scheduler_top_macros.svh"

module credit_limited_chunk_scheduler_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic     [1:0]                    func_i,
  input  wire logic     [cls_pkg::ADDR_W-1:0]    buf_addr_i,
  input  wire logic     [cls_pkg::ADDR_W-1:0]    buf_len_i,
  input  wire logic                              ack_error_i,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic     [cls_pkg::CFG_AW-1:0]    paddr,
  input  wire logic     [cls_pkg::CFG_DW-1:0]    pwdata,
  output logic          [cls_pkg::CFG_DW-1:0]    prdata,
  output logic                                   pready,
  output logic                                   valid_o,
  output logic                                   kind_o,
  output logic          [cls_pkg::ADDR_W-1:0]    chunk_addr_o,
  output logic          [cls_pkg::BLK_W-1:0]     chunk_len_o,
  output logic          [1:0]                    status_o,
  output logic                                   done_valid_o,
  output logic          [cls_pkg::ADDR_W-1:0]    done_addr_o,
  output logic                                   last_o
);

  cls_pkg::cfg_t    cfg;
  cls_pkg::dp_cmd_t cmd;
  cls_pkg::dp_sts_t sts;

  // configuration registers
  cls_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  cls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .func_i      (func_i),
    .ack_error_i (ack_error_i),
    .sts_i       (sts),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  // slot table, credits and result registers
  cls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .buf_addr_i   (buf_addr_i),
    .buf_len_i    (buf_len_i),
    .sts_o        (sts),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .chunk_addr_o (chunk_addr_o),
    .chunk_len_o  (chunk_len_o),
    .status_o     (status_o),
    .done_valid_o (done_valid_o),
    .done_addr_o  (done_addr_o),
    .last_o       (last_o)
  );

  // checks
  `CLS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted transaction not busy")
  `CLS_ASSERT_NOW(a_final_when_idle, valid_o && kind_o, !busy, "final status while still busy")
  `CLS_ASSERT_NOW(a_no_result_unprompted, !$past(busy), !valid_o, "result without transaction")
  `CLS_ASSERT_NOW(a_chunk_len_range, valid_o && !kind_o, (chunk_len_o != '0) && (chunk_len_o <= cls_pkg::CHUNK_MAX), "chunk length out of range")

endmodule

`default_nettype wire

@@ rtl/core/cls_cfg.sv @@
`default_nettype none

module cls_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cls_pkg::CFG_AW-1:0] paddr,
  input  wire logic [cls_pkg::CFG_DW-1:0] pwdata,
  output logic      [cls_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output cls_pkg::cfg_t                   cfg_o
);

  cls_pkg::cfg_t cfg_q;
  cls_pkg::cfg_t cfg_d;
  logic          wr_en;
  cls_pkg::reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = cls_pkg::reg_e'(paddr[cls_pkg::CFG_AW-1:2]);
  assign cfg_o   = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        cls_pkg::REG_BLOCK_BYTES: begin
          cfg_d.block_bytes = pwdata[cls_pkg::BLK_W-1:0];
        end
        cls_pkg::REG_INIT_CREDITS: begin
          cfg_d.initial_credits = pwdata[cls_pkg::INIT_W-1:0];
        end
        cls_pkg::REG_WINDOW_BASE: begin
          cfg_d.window_base = pwdata[cls_pkg::ADDR_W-1:0];
        end
        cls_pkg::REG_WINDOW_SIZE: begin
          cfg_d.window_size = pwdata[cls_pkg::ADDR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_bytes     <= cls_pkg::BLOCK_BYTES_RST;
      cfg_q.initial_credits <= cls_pkg::INIT_CREDITS_RST;
      cfg_q.window_base     <= cls_pkg::WINDOW_BASE_RST;
      cfg_q.window_size     <= cls_pkg::WINDOW_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      cls_pkg::REG_BLOCK_BYTES:  prdata = cls_pkg::CFG_DW'(cfg_q.block_bytes);
      cls_pkg::REG_INIT_CREDITS: prdata = cls_pkg::CFG_DW'(cfg_q.initial_credits);
      cls_pkg::REG_WINDOW_BASE:  prdata = cls_pkg::CFG_DW'(cfg_q.window_base);
      cls_pkg::REG_WINDOW_SIZE:  prdata = cls_pkg::CFG_DW'(cfg_q.window_size);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/cls_ctrl.sv @@
`default_nettype none

module cls_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [1:0]       func_i,
  input  wire logic             ack_error_i,
  input  cls_pkg::dp_sts_t      sts_i,
  output logic                  busy,
  output cls_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SUM,
    ST_DECIDE,
    ST_WALK,
    ST_ISSUE,
    ST_FINAL
  } state_e;

  localparam logic [cls_pkg::SLOT_W-1:0] LAST_IDX = cls_pkg::SLOT_W'(cls_pkg::SLOTS - 1);

  state_e                      state_q, state_d;
  logic [cls_pkg::SLOT_W-1:0]  idx_q, idx_d;
  cls_pkg::fin_e               fin_q, fin_d;

  assign busy = (state_q != ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    fin_d        = fin_q;
    cmd_o        = '0;
    cmd_o.walk_idx = idx_q;
    cmd_o.fin    = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          unique case (cls_pkg::func_e'(func_i))
            cls_pkg::FUNC_START: begin
              state_d = ST_CLEAR;
              fin_d   = cls_pkg::FIN_OK;
            end
            cls_pkg::FUNC_SUBMIT: begin
              state_d = ST_SUM;
            end
            cls_pkg::FUNC_ACK: begin
              if (ack_error_i) begin
                state_d = ST_FINAL;
                fin_d   = cls_pkg::FIN_ERROR;
              end else begin
                state_d = ST_WALK;
                fin_d   = cls_pkg::FIN_ACK;
              end
            end
            default: begin
              state_d = ST_FINAL;
              fin_d   = cls_pkg::FIN_ERROR;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_FINAL;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.reject || sts_i.no_free) begin
          fin_d   = cls_pkg::FIN_REJECT;
          state_d = ST_FINAL;
        end else begin
          cmd_o.alloc = 1'b1;
          fin_d       = cls_pkg::FIN_SUBMIT;
          idx_d       = '0;
          state_d     = ST_ISSUE;
        end
      end
      // one slot per cycle, credit returned on the first
      ST_WALK: begin
        cmd_o.walk   = 1'b1;
        cmd_o.credit = (idx_q == '0);
        if (sts_i.walk_freed || idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_ISSUE;
        end else begin
          idx_d = idx_q + cls_pkg::SLOT_W'(1);
        end
      end
      // one chunk per cycle, idx counts finished buffers
      ST_ISSUE: begin
        if (!sts_i.can_issue) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.issue = 1'b1;
          if (sts_i.ends_buf) begin
            if (idx_q == LAST_IDX) begin
              state_d = ST_FINAL;
            end else begin
              idx_d = idx_q + cls_pkg::SLOT_W'(1);
            end
          end
        end
      end
      ST_FINAL: begin
        cmd_o.emit_fin = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      fin_q   <= cls_pkg::FIN_OK;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cls_dp.sv @@
`default_nettype none

module cls_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  cls_pkg::cfg_t                          cfg_i,
  input  cls_pkg::dp_cmd_t                       cmd_i,
  input  wire logic     [cls_pkg::ADDR_W-1:0]    buf_addr_i,
  input  wire logic     [cls_pkg::ADDR_W-1:0]    buf_len_i,
  output cls_pkg::dp_sts_t                       sts_o,
  output logic                                   valid_o,
  output logic                                   kind_o,
  output logic          [cls_pkg::ADDR_W-1:0]    chunk_addr_o,
  output logic          [cls_pkg::BLK_W-1:0]     chunk_len_o,
  output logic          [1:0]                    status_o,
  output logic                                   done_valid_o,
  output logic          [cls_pkg::ADDR_W-1:0]    done_addr_o,
  output logic                                   last_o
);

  localparam int SL  = cls_pkg::SLOTS;
  localparam int SW  = cls_pkg::SLOT_W;
  localparam int AW  = cls_pkg::ADDR_W;
  localparam int BW  = cls_pkg::BLK_W;
  localparam int CW  = cls_pkg::CRED_W;
  localparam int QW  = cls_pkg::SEQ_BITS;
  localparam int OW  = cls_pkg::OUT_W;

  // slot table
  logic [AW-1:0] sbase_q [SL];
  logic [AW-1:0] sbase_d [SL];
  logic [AW-1:0] slen_q  [SL];
  logic [AW-1:0] slen_d  [SL];
  logic [AW-1:0] ssent_q [SL];
  logic [AW-1:0] ssent_d [SL];
  logic [QW-1:0] sseq_q  [SL];
  logic [QW-1:0] sseq_d  [SL];
  logic [OW-1:0] sout_q  [SL];
  logic [OW-1:0] sout_d  [SL];
  logic [SL-1:0] sbusy_q, sbusy_d;

  // scheduler state
  logic [CW-1:0] credits_q, credits_d;
  logic [SW-1:0] ptr_q, ptr_d;
  logic [QW-1:0] next_seq_q, next_seq_d;
  logic [QW-1:0] expect_q, expect_d;

  // per-transaction registers
  logic [AW-1:0] in_addr_q, in_addr_d;
  logic [AW-1:0] in_len_q, in_len_d;
  logic [AW:0]   end_q, end_d;
  logic [AW:0]   tot_q, tot_d;
  logic          sub_busy_q, sub_busy_d;
  logic          done_q, done_d;
  logic [AW-1:0] done_addr_q, done_addr_d;

  // result registers
  logic          valid_q, valid_d;
  logic          kind_q, kind_d;
  logic [AW-1:0] caddr_q, caddr_d;
  logic [BW-1:0] clen_q, clen_d;
  logic [1:0]    status_q, status_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] da_q, da_d;
  logic          last_q, last_d;

  // combinational helpers
  logic [BW-1:0] blk;
  logic [SW-1:0] sel;
  logic [AW-1:0] rem;
  logic          has_rem;
  logic          ends;
  logic [AW-1:0] chunk_addr;
  logic [AW-1:0] sent_step;
  logic          match;
  logic [OW-1:0] out_dec;
  logic          frees;
  logic [SW-1:0] free_idx;
  logic [CW-1:0] init_cap;
  logic [SW-1:0] ptr_next;

  // chunk size clamped into range
  assign blk = (cfg_i.block_bytes == '0) ? BW'(1) :
               (cfg_i.block_bytes > BW'(cls_pkg::CHUNK_MAX)) ? BW'(cls_pkg::CHUNK_MAX) :
               cfg_i.block_bytes;

  // single slot read port: walk index or issue pointer
  assign sel        = cmd_i.walk ? cmd_i.walk_idx : ptr_q;
  assign rem        = slen_q[sel] - ssent_q[sel];
  assign has_rem    = (rem != '0);
  assign ends       = (rem <= AW'(blk));
  assign chunk_addr = sbase_q[sel] + ssent_q[sel];
  assign sent_step  = ssent_q[sel] + AW'(blk);
  assign ptr_next   = (ptr_q == SW'(SL - 1)) ? '0 : ptr_q + SW'(1);

  // acknowledgement match on the walked slot
  assign match   = sbusy_q[sel] && (sseq_q[sel] == expect_q) && (sout_q[sel] != '0);
  assign out_dec = sout_q[sel] - OW'(1);
  assign frees   = match && (out_dec == '0) && !has_rem;

  assign init_cap = (32'(cfg_i.initial_credits) > cls_pkg::MAX_CREDITS) ?
                    CW'(cls_pkg::MAX_CREDITS) : CW'(cfg_i.initial_credits);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SL - 1; i >= 0; i--) begin
      if (!sbusy_q[i]) free_idx = SW'(i);
    end
  end

  // status to the controller
  assign sts_o.reject     = (in_addr_q < cfg_i.window_base) ||
                            ({1'b0, in_addr_q} > end_q) || (tot_q > end_q);
  assign sts_o.no_free    = &sbusy_q;
  assign sts_o.can_issue  = (credits_q != '0) && has_rem;
  assign sts_o.ends_buf   = ends;
  assign sts_o.walk_freed = frees;

  // next state
  always_comb begin
    sbase_d     = sbase_q;
    slen_d      = slen_q;
    ssent_d     = ssent_q;
    sseq_d      = sseq_q;
    sout_d      = sout_q;
    sbusy_d     = sbusy_q;
    credits_d   = credits_q;
    ptr_d       = ptr_q;
    next_seq_d  = next_seq_q;
    expect_d    = expect_q;
    in_addr_d   = in_addr_q;
    in_len_d    = in_len_q;
    end_d       = end_q;
    tot_d       = tot_q;
    sub_busy_d  = sub_busy_q;
    done_d      = done_q;
    done_addr_d = done_addr_q;
    valid_d     = 1'b0;
    kind_d      = kind_q;
    caddr_d     = caddr_q;
    clen_d      = clen_q;
    status_d    = status_q;
    dv_d        = dv_q;
    da_d        = da_q;
    last_d      = last_q;

    // capture the accepted transaction
    if (cmd_i.load) begin
      in_addr_d   = buf_addr_i;
      in_len_d    = buf_len_i;
      done_d      = 1'b0;
      done_addr_d = '0;
    end

    // start: empty table, load credits
    if (cmd_i.clear) begin
      for (int i = 0; i < SL; i++) begin
        sbase_d[i] = '0;
        slen_d[i]  = '0;
        ssent_d[i] = '0;
        sseq_d[i]  = '0;
        sout_d[i]  = '0;
      end
      sbusy_d    = '0;
      credits_d  = init_cap;
      ptr_d      = '0;
      next_seq_d = '0;
      expect_d   = '0;
    end

    // window end and buffer end for the range check
    if (cmd_i.sum) begin
      end_d = {1'b0, cfg_i.window_base} + {1'b0, cfg_i.window_size};
      tot_d = {1'b0, in_addr_q} + {1'b0, in_len_q};
    end

    // store the submitted buffer
    if (cmd_i.alloc) begin
      sbase_d[free_idx] = in_addr_q;
      slen_d[free_idx]  = in_len_q;
      ssent_d[free_idx] = '0;
      sseq_d[free_idx]  = next_seq_q;
      sout_d[free_idx]  = '0;
      sbusy_d[free_idx] = 1'b1;
      next_seq_d        = next_seq_q + QW'(1);
      sub_busy_d        = (free_idx == SW'(SL - 1));
    end

    // returned credit, saturating
    if (cmd_i.credit) begin
      if (credits_q < CW'(cls_pkg::MAX_CREDITS)) credits_d = credits_q + CW'(1);
    end

    // charge the acknowledgement to the walked slot
    if (cmd_i.walk && match) begin
      sout_d[sel] = out_dec;
      if (frees) begin
        sbusy_d[sel] = 1'b0;
        expect_d     = expect_q + QW'(1);
        done_d       = 1'b1;
        done_addr_d  = sbase_q[sel];
      end
    end

    // issue one chunk from the slot at the pointer
    if (cmd_i.issue) begin
      ssent_d[sel] = ends ? slen_q[sel] : sent_step;
      if (sout_q[sel] < OW'(cls_pkg::OUT_MAX)) sout_d[sel] = sout_q[sel] + OW'(1);
      credits_d = credits_q - CW'(1);
      if (ends) ptr_d = ptr_next;
      valid_d  = 1'b1;
      kind_d   = cls_pkg::KIND_CHUNK;
      caddr_d  = chunk_addr;
      clen_d   = ends ? rem[BW-1:0] : blk;
      status_d = cls_pkg::STAT_OK;
      dv_d     = 1'b0;
      da_d     = '0;
      last_d   = 1'b0;
    end

    // final status of the transaction
    if (cmd_i.emit_fin) begin
      valid_d = 1'b1;
      kind_d  = cls_pkg::KIND_FINAL;
      caddr_d = '0;
      clen_d  = '0;
      dv_d    = done_q;
      da_d    = done_q ? done_addr_q : '0;
      last_d  = 1'b1;
      case (cmd_i.fin)
        cls_pkg::FIN_OK:     status_d = cls_pkg::STAT_OK;
        cls_pkg::FIN_REJECT: status_d = cls_pkg::STAT_REJECT;
        cls_pkg::FIN_ERROR:  status_d = cls_pkg::STAT_ERROR;
        cls_pkg::FIN_SUBMIT: status_d = sub_busy_q ? cls_pkg::STAT_BUSY : cls_pkg::STAT_OK;
        cls_pkg::FIN_ACK: begin
          status_d = (done_q || !(|sbusy_q)) ? cls_pkg::STAT_OK : cls_pkg::STAT_BUSY;
        end
        default:             status_d = cls_pkg::STAT_ERROR;
      endcase
    end
  end

  // table and scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SL; i++) begin
        sbase_q[i] <= '0;
        slen_q[i]  <= '0;
        ssent_q[i] <= '0;
        sseq_q[i]  <= '0;
        sout_q[i]  <= '0;
      end
      sbusy_q    <= '0;
      credits_q  <= '0;
      ptr_q      <= '0;
      next_seq_q <= '0;
      expect_q   <= '0;
      sub_busy_q <= 1'b0;
      done_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      sbase_q    <= sbase_d;
      slen_q     <= slen_d;
      ssent_q    <= ssent_d;
      sseq_q     <= sseq_d;
      sout_q     <= sout_d;
      sbusy_q    <= sbusy_d;
      credits_q  <= credits_d;
      ptr_q      <= ptr_d;
      next_seq_q <= next_seq_d;
      expect_q   <= expect_d;
      sub_busy_q <= sub_busy_d;
      done_q     <= done_d;
      valid_q    <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_addr_q   <= in_addr_d;
    in_len_q    <= in_len_d;
    end_q       <= end_d;
    tot_q       <= tot_d;
    done_addr_q <= done_addr_d;
    kind_q      <= kind_d;
    caddr_q     <= caddr_d;
    clen_q      <= clen_d;
    status_q    <= status_d;
    dv_q        <= dv_d;
    da_q        <= da_d;
    last_q      <= last_d;
  end

  assign valid_o      = valid_q;
  assign kind_o       = kind_q;
  assign chunk_addr_o = caddr_q;
  assign chunk_len_o  = clen_q;
  assign status_o     = status_q;
  assign done_valid_o = dv_q;
  assign done_addr_o  = da_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
